// ===== rtl/bar_graph_level_brightness_top_macros.svh =====
// assertion helpers for the bar graph level meter
`ifndef BAR_GRAPH_LEVEL_BRIGHTNESS_TOP_MACROS_SVH
`define BAR_GRAPH_LEVEL_BRIGHTNESS_TOP_MACROS_SVH

// condition must hold in the same cycle
`define BGLB_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("bglb: same cycle check failed");

// condition must hold in the next cycle
`define BGLB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("bglb: next cycle check failed");

`endif

// ===== rtl/bglb_pkg.sv =====
package bglb_pkg;

	localparam int SEG_W = 5;
	localparam int HUE_W = 7;
	localparam int BRT_W = 8;
	localparam int VAL_W = 16;
	localparam int IDX_W = 2;
	localparam int STEP_W = 16;
	localparam int DIST_W = 19;
	localparam int DIV_W = 15;
	localparam int NUM_W = 23;
	localparam int QUO_W = 8;
	localparam int RCP_W = 20;
	localparam int RCP_SHIFT = 21;
	localparam int RCP_ONE = 1 << RCP_SHIFT;
	localparam int HUE_GREEN_I = 120;
	localparam int HQ_W = 6;
	localparam int HR_W = 5;

	localparam logic [BRT_W-1:0] BRIGHT_FULL = 8'd255;
	localparam logic [BRT_W-1:0] BRIGHT_DIM = 8'd20;
	localparam logic [BRT_W-1:0] BRIGHT_SPAN = 8'd235;
	localparam logic [HUE_W-1:0] HUE_GREEN = 7'd120;
	localparam logic signed [VAL_W-1:0] DEFAULT_LOW = 16'sd1;
	localparam logic signed [VAL_W-1:0] DEFAULT_HIGH = 16'sd100;
	localparam logic [SEG_W-1:0] DEFAULT_COUNT = 5'd9;
	localparam logic [SEG_W-1:0] MIN_COUNT = 5'd3;

	typedef enum logic [IDX_W-1:0] {
		REG_RANGE_LOW = 2'd0,
		REG_RANGE_HIGH = 2'd1,
		REG_SEGMENT_COUNT = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [HQ_W-1:0] quot;
		logic [HR_W-1:0] rem;
	} hue_inc_t;

	typedef struct packed {
		logic [SEG_W-1:0] count;
		logic signed [STEP_W-1:0] step;
		logic signed [DIST_W-1:0] offs;
	} item_t;

	typedef struct packed {
		logic [SEG_W-1:0] seg;
		logic [HUE_W-1:0] hue;
		logic last;
		logic signed [DIST_W-1:0] offs;
		logic signed [STEP_W-1:0] step;
	} job_t;

	// scaled reciprocal of the segment count, exact for 16 bit dividends
	function automatic logic [RCP_W-1:0] recip(input logic [SEG_W-1:0] n);
		logic [RCP_W-1:0] r;
		case (n)
			5'd3: r = RCP_W'((RCP_ONE + 2) / 3);
			5'd4: r = RCP_W'((RCP_ONE + 3) / 4);
			5'd5: r = RCP_W'((RCP_ONE + 4) / 5);
			5'd6: r = RCP_W'((RCP_ONE + 5) / 6);
			5'd7: r = RCP_W'((RCP_ONE + 6) / 7);
			5'd8: r = RCP_W'((RCP_ONE + 7) / 8);
			5'd9: r = RCP_W'((RCP_ONE + 8) / 9);
			5'd10: r = RCP_W'((RCP_ONE + 9) / 10);
			5'd11: r = RCP_W'((RCP_ONE + 10) / 11);
			5'd12: r = RCP_W'((RCP_ONE + 11) / 12);
			5'd13: r = RCP_W'((RCP_ONE + 12) / 13);
			5'd14: r = RCP_W'((RCP_ONE + 13) / 14);
			5'd15: r = RCP_W'((RCP_ONE + 14) / 15);
			5'd16: r = RCP_W'((RCP_ONE + 15) / 16);
			5'd17: r = RCP_W'((RCP_ONE + 16) / 17);
			5'd18: r = RCP_W'((RCP_ONE + 17) / 18);
			5'd19: r = RCP_W'((RCP_ONE + 18) / 19);
			default: r = '0;
		endcase
		return r;
	endfunction

	// hue increment per segment: 120 / (n - 1) as quotient and remainder
	function automatic hue_inc_t hue_inc(input logic [SEG_W-1:0] n);
		hue_inc_t h;
		case (n)
			5'd3: h = '{quot: HQ_W'(HUE_GREEN_I / 2), rem: HR_W'(HUE_GREEN_I % 2)};
			5'd4: h = '{quot: HQ_W'(HUE_GREEN_I / 3), rem: HR_W'(HUE_GREEN_I % 3)};
			5'd5: h = '{quot: HQ_W'(HUE_GREEN_I / 4), rem: HR_W'(HUE_GREEN_I % 4)};
			5'd6: h = '{quot: HQ_W'(HUE_GREEN_I / 5), rem: HR_W'(HUE_GREEN_I % 5)};
			5'd7: h = '{quot: HQ_W'(HUE_GREEN_I / 6), rem: HR_W'(HUE_GREEN_I % 6)};
			5'd8: h = '{quot: HQ_W'(HUE_GREEN_I / 7), rem: HR_W'(HUE_GREEN_I % 7)};
			5'd9: h = '{quot: HQ_W'(HUE_GREEN_I / 8), rem: HR_W'(HUE_GREEN_I % 8)};
			5'd10: h = '{quot: HQ_W'(HUE_GREEN_I / 9), rem: HR_W'(HUE_GREEN_I % 9)};
			5'd11: h = '{quot: HQ_W'(HUE_GREEN_I / 10), rem: HR_W'(HUE_GREEN_I % 10)};
			5'd12: h = '{quot: HQ_W'(HUE_GREEN_I / 11), rem: HR_W'(HUE_GREEN_I % 11)};
			5'd13: h = '{quot: HQ_W'(HUE_GREEN_I / 12), rem: HR_W'(HUE_GREEN_I % 12)};
			5'd14: h = '{quot: HQ_W'(HUE_GREEN_I / 13), rem: HR_W'(HUE_GREEN_I % 13)};
			5'd15: h = '{quot: HQ_W'(HUE_GREEN_I / 14), rem: HR_W'(HUE_GREEN_I % 14)};
			5'd16: h = '{quot: HQ_W'(HUE_GREEN_I / 15), rem: HR_W'(HUE_GREEN_I % 15)};
			5'd17: h = '{quot: HQ_W'(HUE_GREEN_I / 16), rem: HR_W'(HUE_GREEN_I % 16)};
			5'd18: h = '{quot: HQ_W'(HUE_GREEN_I / 17), rem: HR_W'(HUE_GREEN_I % 17)};
			5'd19: h = '{quot: HQ_W'(HUE_GREEN_I / 18), rem: HR_W'(HUE_GREEN_I % 18)};
			default: h = '{quot: '0, rem: '0};
		endcase
		return h;
	endfunction

endpackage

// ===== rtl/bglb_prep.sv =====
module bglb_prep (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               sample_valid,
	output logic                               sample_stall,
	input  logic signed [bglb_pkg::VAL_W-1:0]  sample,
	input  logic signed [bglb_pkg::VAL_W-1:0]  range_low,
	input  logic signed [bglb_pkg::VAL_W-1:0]  range_high,
	input  logic        [bglb_pkg::SEG_W-1:0]  count,
	output logic                               item_valid,
	output bglb_pkg::item_t                    item,
	input  logic                               item_take
);
	import bglb_pkg::*;

	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy1, rdy2, rdy3, rdy4;

	logic signed [VAL_W-1:0] lo_e, hi_e, s_c;
	logic signed [VAL_W:0] diff, diff_neg, rel;

	logic neg_s1, neg_s2;
	logic [VAL_W-1:0] mag_s1;
	logic [RCP_W-1:0] rcp_s1;
	logic signed [VAL_W:0] rel_s1, rel_s2, rel_s3;
	logic [SEG_W-1:0] n_s1, n_s2, n_s3, n_s4;
	logic [DIV_W-1:0] q_s2;
	logic signed [STEP_W-1:0] step_s3, step_s4;
	logic signed [DIST_W-1:0] dist_s4;

	logic [VAL_W+RCP_W-1:0] prod;
	logic signed [STEP_W-1:0] q_sx, step_nx;
	logic [SEG_W-1:0] nm1;
	logic signed [DIST_W-1:0] tw, dist_nx;

	assign rdy4 = !v_s4 || item_take;
	assign rdy3 = !v_s3 || rdy4;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;
	assign sample_stall = !rdy1;

	// equal ends select the range 0 to 100, then clamp
	always_comb begin
		if (range_low == range_high) begin
			lo_e = '0;
			hi_e = DEFAULT_HIGH;
		end else begin
			lo_e = range_low;
			hi_e = range_high;
		end
		s_c = sample;
		if (s_c < lo_e) begin
			s_c = lo_e;
		end
		if (s_c > hi_e) begin
			s_c = hi_e;
		end
		diff = (VAL_W+1)'(hi_e) - (VAL_W+1)'(lo_e);
		diff_neg = -diff;
		rel = (VAL_W+1)'(s_c) - (VAL_W+1)'(lo_e);
	end

	assign prod = (VAL_W+RCP_W)'(mag_s1) * (VAL_W+RCP_W)'(rcp_s1);
	assign q_sx = $signed({1'b0, q_s2});
	assign step_nx = neg_s2 ? -q_sx : q_sx;
	assign nm1 = n_s3 - SEG_W'(1);
	assign tw = DIST_W'($signed({1'b0, nm1})) * DIST_W'(step_s3);
	assign dist_nx = DIST_W'(rel_s3) - tw;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy1) begin
				v_s1 <= sample_valid;
			end
			if (rdy2) begin
				v_s2 <= v_s1;
			end
			if (rdy3) begin
				v_s3 <= v_s2;
			end
			if (rdy4) begin
				v_s4 <= v_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && sample_valid) begin
			neg_s1 <= diff[VAL_W];
			mag_s1 <= diff[VAL_W] ? diff_neg[VAL_W-1:0] : diff[VAL_W-1:0];
			rcp_s1 <= recip(count);
			rel_s1 <= rel;
			n_s1 <= count;
		end
		if (rdy2 && v_s1) begin
			q_s2 <= prod[RCP_SHIFT +: DIV_W];
			neg_s2 <= neg_s1;
			rel_s2 <= rel_s1;
			n_s2 <= n_s1;
		end
		if (rdy3 && v_s2) begin
			step_s3 <= step_nx;
			rel_s3 <= rel_s2;
			n_s3 <= n_s2;
		end
		if (rdy4 && v_s3) begin
			step_s4 <= step_s3;
			dist_s4 <= dist_nx;
			n_s4 <= n_s3;
		end
	end

	assign item_valid = v_s4;
	assign item.count = n_s4;
	assign item.step = step_s4;
	assign item.offs = dist_s4;

endmodule

// ===== rtl/bglb_expand.sv =====
module bglb_expand (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	input  bglb_pkg::item_t item,
	output logic            item_take,
	input  logic            advance,
	output logic            job_valid,
	output bglb_pkg::job_t  job
);
	import bglb_pkg::*;

	logic busy_q;
	logic [SEG_W-1:0] seg_q, nm1_q;
	logic [HUE_W-1:0] hue_q, hue_nx;
	logic [HR_W-1:0] hr_q, hr_nx;
	logic [HR_W:0] hr_sum;
	hue_inc_t inc_q;
	logic signed [DIST_W-1:0] dist_q;
	logic signed [STEP_W-1:0] step_q;
	logic done;

	assign done = (seg_q == '0);
	assign item_take = item_valid && (!busy_q || (advance && done));

	// running hue with at most one correction per segment
	always_comb begin
		hr_sum = (HR_W+1)'(hr_q) + (HR_W+1)'(inc_q.rem);
		if (hr_sum >= (HR_W+1)'(nm1_q)) begin
			hr_nx = HR_W'(hr_sum - (HR_W+1)'(nm1_q));
			hue_nx = hue_q + HUE_W'(inc_q.quot) + HUE_W'(1);
		end else begin
			hr_nx = hr_sum[HR_W-1:0];
			hue_nx = hue_q + HUE_W'(inc_q.quot);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (item_take) begin
			busy_q <= 1'b1;
		end else if (advance && done) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_take) begin
			seg_q <= item.count - SEG_W'(1);
			nm1_q <= item.count - SEG_W'(1);
			hue_q <= '0;
			hr_q <= '0;
			inc_q <= hue_inc(item.count);
			dist_q <= item.offs;
			step_q <= item.step;
		end else if (advance && busy_q) begin
			seg_q <= seg_q - SEG_W'(1);
			dist_q <= dist_q + DIST_W'(step_q);
			hue_q <= hue_nx;
			hr_q <= hr_nx;
		end
	end

	assign job_valid = busy_q;
	assign job.seg = seg_q;
	assign job.hue = hue_q;
	assign job.last = done;
	assign job.offs = dist_q;
	assign job.step = step_q;

endmodule

// ===== rtl/bglb_shade.sv =====
module bglb_shade (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        job_valid,
	input  bglb_pkg::job_t              job,
	output logic                        advance,
	output logic                        result_valid,
	input  logic                        result_stall,
	output logic [bglb_pkg::SEG_W-1:0]  segment,
	output logic [bglb_pkg::HUE_W-1:0]  hue,
	output logic [bglb_pkg::BRT_W-1:0]  brightness,
	output logic                        last
);
	import bglb_pkg::*;

	typedef enum logic [1:0] {
		CLS_DIM,
		CLS_FULL,
		CLS_PROP
	} cls_t;

	cls_t cls_nx;
	logic [NUM_W-1:0] num_nx;

	logic vld_s [0:QUO_W];
	logic [NUM_W-1:0] rem_s [0:QUO_W];
	logic [QUO_W-1:0] quo_s [0:QUO_W];
	logic [DIV_W-1:0] div_s [0:QUO_W];
	cls_t cls_s [0:QUO_W];
	logic [SEG_W-1:0] seg_s [0:QUO_W];
	logic [HUE_W-1:0] hue_s [0:QUO_W];
	logic last_s [0:QUO_W];

	logic [NUM_W-1:0] trial [1:QUO_W];
	logic fits [1:QUO_W];

	logic valid_s10;
	logic [SEG_W-1:0] segment_s10;
	logic [HUE_W-1:0] hue_s10;
	logic [BRT_W-1:0] brightness_s10;
	logic last_s10;

	assign advance = !(valid_s10 && result_stall);

	always_comb begin
		if (job.offs >= DIST_W'(job.step)) begin
			cls_nx = CLS_FULL;
		end else if (job.offs <= DIST_W'(0)) begin
			cls_nx = CLS_DIM;
		end else begin
			cls_nx = CLS_PROP;
		end
		num_nx = NUM_W'(BRIGHT_SPAN) * NUM_W'(job.offs[DIV_W-1:0]);
	end

	// one quotient bit per stage, msb first
	always_comb begin
		for (int j = 1; j <= QUO_W; j++) begin
			trial[j] = NUM_W'(div_s[j-1]) << (QUO_W - j);
			fits[j] = rem_s[j-1] >= trial[j];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j <= QUO_W; j++) begin
				vld_s[j] <= 1'b0;
			end
			valid_s10 <= 1'b0;
		end else if (advance) begin
			vld_s[0] <= job_valid;
			for (int j = 1; j <= QUO_W; j++) begin
				vld_s[j] <= vld_s[j-1];
			end
			valid_s10 <= vld_s[QUO_W];
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rem_s[0] <= num_nx;
			quo_s[0] <= '0;
			div_s[0] <= job.step[DIV_W-1:0];
			cls_s[0] <= cls_nx;
			seg_s[0] <= job.seg;
			hue_s[0] <= job.hue;
			last_s[0] <= job.last;
			for (int j = 1; j <= QUO_W; j++) begin
				rem_s[j] <= fits[j] ? rem_s[j-1] - trial[j] : rem_s[j-1];
				quo_s[j] <= {quo_s[j-1][QUO_W-2:0], fits[j]};
				div_s[j] <= div_s[j-1];
				cls_s[j] <= cls_s[j-1];
				seg_s[j] <= seg_s[j-1];
				hue_s[j] <= hue_s[j-1];
				last_s[j] <= last_s[j-1];
			end
			segment_s10 <= seg_s[QUO_W];
			hue_s10 <= hue_s[QUO_W];
			last_s10 <= last_s[QUO_W];
			case (cls_s[QUO_W])
				CLS_FULL: brightness_s10 <= BRIGHT_FULL;
				CLS_DIM: brightness_s10 <= BRIGHT_DIM;
				CLS_PROP: brightness_s10 <= BRIGHT_DIM + quo_s[QUO_W];
				default: brightness_s10 <= BRIGHT_DIM;
			endcase
		end
	end

	assign result_valid = valid_s10;
	assign segment = segment_s10;
	assign hue = hue_s10;
	assign brightness = brightness_s10;
	assign last = last_s10;

endmodule

// ===== rtl/bar_graph_level_brightness_top.sv =====
// LED bar graph level meter. Each accepted sample is clamped into the
// configured range (equal ends mean 0 to 100) and expands into one result
// per segment, highest segment first, with last set on segment zero. The
// segment expander sends one result per cycle while the output is not
// stalled, so a sample yields segment_count results (3 to 19, 9 after
// reset) and samples follow each other with no gap; up to four samples
// wait in the input stages while a run is in progress. On its way to the
// first result a sample passes four stages that find the step width by
// reciprocal multiply, the expander register with the current segment,
// and then, per segment, a classify stage, an eight stage divider for the
// proportional brightness and the output register. A result stall holds
// the expander and the stages after it. Registers may be written only while
// no sample is in flight.
module bar_graph_level_brightness_top #(
	parameter int MAX_SEGMENTS = 19
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [bglb_pkg::IDX_W-1:0]         cfg_index,
	input  logic [bglb_pkg::VAL_W-1:0]         cfg_data,
	input  logic                               sample_valid,
	output logic                               sample_stall,
	input  logic signed [bglb_pkg::VAL_W-1:0]  sample,
	output logic                               result_valid,
	input  logic                               result_stall,
	output logic [bglb_pkg::SEG_W-1:0]         segment,
	output logic [bglb_pkg::HUE_W-1:0]         hue,
	output logic [bglb_pkg::BRT_W-1:0]         brightness,
	output logic                               last
);
	import bglb_pkg::*;

	localparam logic [SEG_W-1:0] MAX_COUNT = SEG_W'(MAX_SEGMENTS);
	localparam logic [SEG_W-1:0] RESET_COUNT =
		(DEFAULT_COUNT <= MAX_COUNT) ? DEFAULT_COUNT : MAX_COUNT;

	logic signed [VAL_W-1:0] range_low_q, range_high_q;
	logic [SEG_W-1:0] count_q;
	logic [SEG_W-1:0] count_wr;

	logic item_valid, item_take, job_valid, advance;
	item_t item;
	job_t job;

	assign count_wr = cfg_data[SEG_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_low_q <= DEFAULT_LOW;
			range_high_q <= DEFAULT_HIGH;
			count_q <= RESET_COUNT;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_RANGE_LOW: range_low_q <= $signed(cfg_data);
				REG_RANGE_HIGH: range_high_q <= $signed(cfg_data);
				REG_SEGMENT_COUNT: begin
					if (count_wr >= MIN_COUNT && count_wr <= MAX_COUNT) begin
						count_q <= count_wr;
					end
				end
				default: ;
			endcase
		end
	end

	bglb_prep u_prep (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.range_low    (range_low_q),
		.range_high   (range_high_q),
		.count        (count_q),
		.item_valid   (item_valid),
		.item         (item),
		.item_take    (item_take)
	);

	bglb_expand u_expand (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item       (item),
		.item_take  (item_take),
		.advance    (advance),
		.job_valid  (job_valid),
		.job        (job)
	);

	bglb_shade u_shade (
		.clk          (clk),
		.arst_n       (arst_n),
		.job_valid    (job_valid),
		.job          (job),
		.advance      (advance),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.segment      (segment),
		.hue          (hue),
		.brightness   (brightness),
		.last         (last)
	);

endmodule

// ===== rtl/bglb_checker.sv =====
`include "bar_graph_level_brightness_top_macros.svh"

module bglb_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               result_valid,
	input logic                               result_stall,
	input logic [bglb_pkg::SEG_W-1:0]         segment,
	input logic [bglb_pkg::HUE_W-1:0]         hue,
	input logic [bglb_pkg::BRT_W-1:0]         brightness,
	input logic                               last
);
	import bglb_pkg::*;

	// a stalled result holds
	`BGLB_ASSERT_NEXT(a_hold, clk, arst_n, result_valid && result_stall, result_valid && $stable(segment) && $stable(hue) && $stable(brightness) && $stable(last))

	// a run comes out without gaps, one segment lower each transfer
	`BGLB_ASSERT_NEXT(a_run, clk, arst_n, result_valid && !result_stall && !last, result_valid && (segment == $past(segment) - SEG_W'(1)))

	// last marks segment zero and nothing else
	`BGLB_ASSERT_SAME(a_last, clk, arst_n, result_valid, last == (segment == '0))

	// segment zero is always pure green
	`BGLB_ASSERT_SAME(a_green, clk, arst_n, result_valid && last, hue == HUE_GREEN && brightness >= BRIGHT_DIM)

endmodule

bind bar_graph_level_brightness_top bglb_checker u_checker (.*);

// ===== verif/bar_graph_level_brightness_top_tb.sv =====
`timescale 1ns / 1ps

module bar_graph_level_brightness_top_tb;
	import bglb_pkg::*;

	localparam int MAX_SEGMENTS = 19;
	localparam int CLK_PERIOD = 10;
	localparam int RESET_CYCLES = 5;
	localparam int IDLE_PCT = 35;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_CYCLES = 24;
	localparam int END_CYCLES = 60;
	localparam int RANDOM_ITEMS = 32;
	localparam longint TIMEOUT_NS = 4_000_000;
	localparam logic [IDX_W-1:0] REG_SPARE = 2'd3;
	localparam longint LVL_FULL = BRIGHT_FULL;
	localparam longint LVL_DIM = BRIGHT_DIM;
	localparam longint LVL_SPAN = BRIGHT_SPAN;
	localparam longint HUE_TOP = HUE_GREEN;
	localparam longint EQ_HIGH = DEFAULT_HIGH;

	typedef struct packed {
		logic [SEG_W-1:0] seg;
		logic [HUE_W-1:0] hue;
		logic [BRT_W-1:0] brt;
		logic last;
	} seg_result_t;

	class meter_scoreboard;
		logic signed [VAL_W-1:0] low_q;
		logic signed [VAL_W-1:0] high_q;
		logic [SEG_W-1:0] count_q;
		seg_result_t expected_segments[$];
		int errors;

		function new();
			low_q = DEFAULT_LOW;
			high_q = DEFAULT_HIGH;
			count_q = DEFAULT_COUNT;
			errors = 0;
		endfunction

		function void set_reg(logic [IDX_W-1:0] idx, logic [VAL_W-1:0] data);
			if (idx == REG_RANGE_LOW) begin
				low_q = signed'(data);
			end else if (idx == REG_RANGE_HIGH) begin
				high_q = signed'(data);
			end else if (idx == REG_SEGMENT_COUNT) begin
				if (data[SEG_W-1:0] >= MIN_COUNT && data[SEG_W-1:0] <= MAX_SEGMENTS) begin
					count_q = data[SEG_W-1:0];
				end
			end
		endfunction

		function int pending();
			return expected_segments.size();
		endfunction

		// one expected result per segment, top segment first
		function void note_sample(logic signed [VAL_W-1:0] v);
			longint lo, hi, n, s, w, i, b, h;
			seg_result_t r;
			lo = low_q;
			hi = high_q;
			n = count_q;
			if (lo == hi) begin
				lo = 0;
				hi = EQ_HIGH;
			end
			s = v;
			if (s < lo) begin
				s = lo;
			end
			if (s > hi) begin
				s = hi;
			end
			w = (hi - lo) / n;
			for (i = n - 1; i >= 0; i--) begin
				h = (n - i - 1) * HUE_TOP / (n - 1);
				if (s >= lo + (i + 1) * w) begin
					b = LVL_FULL;
				end else if (s <= lo + i * w) begin
					b = LVL_DIM;
				end else begin
					b = LVL_DIM + LVL_SPAN * (s - lo - i * w) / w;
				end
				r.seg = SEG_W'(i);
				r.hue = HUE_W'(h);
				r.brt = BRT_W'(b);
				r.last = (i == 0);
				expected_segments.push_back(r);
			end
		endfunction

		function void compare_field(string name, int exp_v, int act_v);
			if (exp_v != act_v) begin
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v,
					act_v);
				errors++;
			end
		endfunction

		function void check_segment(logic [SEG_W-1:0] seg, logic [HUE_W-1:0] hue,
				logic [BRT_W-1:0] brt, logic last);
			seg_result_t e;
			if (expected_segments.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual segment %0d", $time,
					seg);
				errors++;
				return;
			end
			e = expected_segments.pop_front();
			compare_field("segment", e.seg, seg);
			compare_field("hue", e.hue, hue);
			compare_field("brightness", e.brt, brt);
			compare_field("last", e.last, last);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [IDX_W-1:0] cfg_index = '0;
	logic [VAL_W-1:0] cfg_data = '0;
	logic sample_valid = 1'b0;
	logic sample_stall;
	logic signed [VAL_W-1:0] sample = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	logic [SEG_W-1:0] segment;
	logic [HUE_W-1:0] hue;
	logic [BRT_W-1:0] brightness;
	logic last;

	logic src_idle = 1'b1;
	logic sink_idle = 1'b1;
	logic hold_go = 1'b0;
	int hold_left = 0;

	meter_scoreboard sb = new();

	bar_graph_level_brightness_top #(
		.MAX_SEGMENTS(MAX_SEGMENTS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.sample(sample),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.segment(segment),
		.hue(hue),
		.brightness(brightness),
		.last(last)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// receiver: random stalls, or a long hold-off on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
			hold_left <= 0;
		end else if (hold_go && hold_left == 0) begin
			hold_left <= HOLD_CYCLES;
			result_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			result_stall <= 1'b1;
		end else if (sink_idle) begin
			result_stall <= ($urandom_range(99) < IDLE_PCT);
		end else begin
			result_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			sb.check_segment(segment, hue, brightness, last);
		end
	end

	initial begin
		#(TIMEOUT_NS);
		$display("Verification failed");
		$finish;
	end

	task automatic send_sample(input logic signed [VAL_W-1:0] v);
		sample_valid <= 1'b1;
		sample <= v;
		@(posedge clk);
		while (sample_stall) begin
			@(posedge clk);
		end
		sb.note_sample(v);
		if (src_idle && $urandom_range(99) < IDLE_PCT) begin
			sample_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	task automatic wait_results();
		while (sb.pending() != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic drain();
		sample_valid <= 1'b0;
		wait_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [IDX_W-1:0] idx, input logic [VAL_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		sb.set_reg(idx, data);
	endtask

	task automatic set_range(input logic [VAL_W-1:0] lo, input logic [VAL_W-1:0] hi,
			input logic [VAL_W-1:0] cnt);
		drain();
		cfg_write(REG_RANGE_LOW, lo);
		cfg_write(REG_RANGE_HIGH, hi);
		cfg_write(REG_SEGMENT_COUNT, cnt);
		cfg_we <= 1'b0;
	endtask

	// mostly around the range, some anywhere in the 16 bit space
	function automatic logic signed [VAL_W-1:0] pick_sample();
		longint a, b, v;
		a = (sb.low_q < sb.high_q) ? sb.low_q : sb.high_q;
		b = (sb.low_q < sb.high_q) ? sb.high_q : sb.low_q;
		if (a == b) begin
			a = 0;
			b = EQ_HIGH;
		end
		if ($urandom_range(99) < 25) begin
			return VAL_W'($urandom());
		end
		v = a - 4 + longint'($urandom_range(int'(b - a + 8)));
		if (v < -32768) begin
			v = -32768;
		end
		if (v > 32767) begin
			v = 32767;
		end
		return VAL_W'(v);
	endfunction

	task automatic run_random(input logic [VAL_W-1:0] lo, input logic [VAL_W-1:0] hi,
			input logic [VAL_W-1:0] cnt, input bit idle_on, input bit hold,
			input bit pause_mid);
		set_range(lo, hi, cnt);
		src_idle <= idle_on;
		sink_idle <= idle_on;
		if (hold) begin
			hold_go <= 1'b1;
			@(posedge clk);
			hold_go <= 1'b0;
		end
		for (int k = 0; k < RANDOM_ITEMS; k++) begin
			if (pause_mid && k == RANDOM_ITEMS / 2) begin
				sample_valid <= 1'b0;
				wait_results();
			end
			send_sample(pick_sample());
		end
	endtask

	initial begin
		logic [VAL_W-1:0] r_lo, r_hi, tmp;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: 1 to 100, nine segments
		send_sample(16'sh8000);
		send_sample(16'sh7fff);
		send_sample(16'sd0);
		send_sample(16'sd1);
		send_sample(16'sd100);
		send_sample(16'sd101);
		send_sample(16'sd50);
		send_sample(16'sd12);
		send_sample(16'sd11);
		send_sample(16'sd23);
		send_sample(-16'sd1);

		// out of range counts and the unused index leave the settings alone
		drain();
		cfg_write(REG_SEGMENT_COUNT, 16'd2);
		cfg_write(REG_SEGMENT_COUNT, 16'd20);
		cfg_write(REG_SEGMENT_COUNT, 16'd0);
		cfg_write(REG_SEGMENT_COUNT, 16'd31);
		cfg_write(REG_SPARE, 16'h1234);
		cfg_we <= 1'b0;
		send_sample(16'sd60);
		send_sample(16'sd90);

		// equal ends, count taken from the low five bits
		set_range(16'hfff9, 16'hfff9, 16'hffe5);
		send_sample(16'sd0);
		send_sample(16'sd100);
		send_sample(16'sd50);
		send_sample(-16'sd7);

		// step width of zero
		set_range(16'd0, 16'd5, 16'd9);
		send_sample(-16'sd1);
		send_sample(16'sd0);
		send_sample(16'sd3);
		send_sample(16'sd5);

		// inverted range
		set_range(16'd100, 16'hff9c, 16'd4);
		send_sample(16'sd0);
		send_sample(16'sh8000);
		send_sample(16'sh7fff);

		run_random(16'h8000, 16'h7fff, 16'd19, 1'b1, 1'b0, 1'b0);
		run_random(16'h8000, 16'h7fff, 16'd3, 1'b1, 1'b0, 1'b0);
		run_random(16'd0, 16'd255, 16'd8, 1'b1, 1'b0, 1'b0);
		run_random(16'hffce, 16'd50, 16'd10, 1'b0, 1'b1, 1'b0);
		run_random(16'h7fff, 16'h8000, 16'd5, 1'b1, 1'b0, 1'b0);
		run_random(16'd10, 16'd10, 16'd19, 1'b1, 1'b0, 1'b0);
		run_random(16'd3, 16'd7, 16'd19, 1'b1, 1'b0, 1'b0);
		r_lo = VAL_W'($urandom());
		r_hi = VAL_W'($urandom());
		if ($signed(r_lo) > $signed(r_hi)) begin
			tmp = r_lo;
			r_lo = r_hi;
			r_hi = tmp;
		end
		run_random(r_lo, r_hi, VAL_W'($urandom_range(3, MAX_SEGMENTS)), 1'b1, 1'b0, 1'b1);
		run_random(VAL_W'($urandom()), VAL_W'($urandom()),
			VAL_W'($urandom_range(3, MAX_SEGMENTS)), 1'b1, 1'b0, 1'b0);
		run_random(VAL_W'($urandom_range(0, 200) - 100), VAL_W'($urandom_range(0, 400)),
			VAL_W'($urandom_range(3, MAX_SEGMENTS)), 1'b1, 1'b0, 1'b0);

		sample_valid <= 1'b0;
		wait_results();
		repeat (END_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
